// ===== design/b64x_pkg.sv =====
// Shared types, constants and the character table for the keyed base64 encoder.
// No dependencies; used by every module of the block.
package b64x_pkg;

  localparam int unsigned MAX_KEY_BYTES = 16;
  localparam logic [7:0]  PAD_CHAR      = 8'h3D;

  // Configuration register indexes.
  localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [1:0] CFG_KEY_LEN  = 2'd2;

  // One finished group: four characters, first one in slot 0.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic            eom;
  } group_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// ===== design/b64x_pack.sv =====
// Input stage: key XOR, group assembly and character mapping of one beat.
// Depends on b64x_pkg.
module b64x_pack (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  input  logic [127:0]          key,
  input  logic [4:0]            key_len,
  output logic                  grp_valid,
  output b64x_pkg::group_t      grp
);

  localparam logic [4:0] MAX_LEN = 5'(b64x_pkg::MAX_KEY_BYTES);

  logic [15:0] held_r, held_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic [3:0]  pos_r,  pos_nxt;

  logic [4:0]  len_eff;
  logic [4:0]  pos_inc;
  logic [7:0]  b;
  logic [23:0] word;
  logic        complete;

  always_comb begin
    len_eff  = (key_len > MAX_LEN) ? MAX_LEN : key_len;
    pos_inc  = {1'b0, pos_r} + 5'd1;
    b        = data_byte;
    pos_nxt  = pos_r;
    if (len_eff != 5'd0) begin
      b       = data_byte ^ key[{pos_r, 3'b000} +: 8];
      pos_nxt = (pos_inc >= len_eff) ? 4'd0 : pos_inc[3:0];
    end
    complete = last_byte || (fill_r == 2'd2);

    case (fill_r)
      2'd0:    word = {b, 16'h0000};
      2'd1:    word = {held_r[15:8], b, 8'h00};
      default: word = {held_r, b};
    endcase

    grp.chars[0] = b64x_pkg::sextet_char(word[23:18]);
    grp.chars[1] = b64x_pkg::sextet_char(word[17:12]);
    grp.chars[2] = (fill_r >= 2'd1) ? b64x_pkg::sextet_char(word[11:6])
                                    : b64x_pkg::PAD_CHAR;
    grp.chars[3] = (fill_r >= 2'd2) ? b64x_pkg::sextet_char(word[5:0])
                                    : b64x_pkg::PAD_CHAR;
    grp.eom      = last_byte;
    grp_valid    = accept && complete;

    held_nxt = held_r;
    fill_nxt = fill_r;
    if (complete) begin
      held_nxt = 16'h0000;
      fill_nxt = 2'd0;
      if (last_byte) begin
        pos_nxt = 4'd0;
      end
    end else if (fill_r == 2'd0) begin
      held_nxt = {b, 8'h00};
      fill_nxt = 2'd1;
    end else begin
      held_nxt = {held_r[15:8], b};
      fill_nxt = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 16'h0000;
      fill_r <= 2'd0;
      pos_r  <= 4'd0;
    end else if (accept) begin
      held_r <= held_nxt;
      fill_r <= fill_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

// ===== design/b64x_ser.sv =====
// Output stage: a pending group slot and an active group sent one character a beat while out_stall is low.
// Depends on b64x_pkg.
module b64x_ser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              grp_valid,
  input  b64x_pkg::group_t  grp,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_char,
  output logic              out_end_of_message
);

  b64x_pkg::group_t act_r, act_nxt;
  b64x_pkg::group_t pend_r, pend_nxt;
  logic             act_valid_r, act_valid_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic             out_fire;
  logic             act_free;

  assign full               = pend_valid_r;
  assign out_valid          = act_valid_r;
  assign out_char           = act_r.chars[idx_r];
  assign out_end_of_message = act_r.eom && (idx_r == 2'd3);

  always_comb begin
    out_fire       = act_valid_r && !out_stall;
    act_free       = !act_valid_r || (out_fire && (idx_r == 2'd3));
    act_nxt        = act_r;
    pend_nxt       = pend_r;
    act_valid_nxt  = act_valid_r;
    pend_valid_nxt = pend_valid_r;
    idx_nxt        = idx_r;

    if (act_free) begin
      // The pending group goes first so that groups leave in arrival order.
      idx_nxt = 2'd0;
      if (pend_valid_r) begin
        act_nxt        = pend_r;
        act_valid_nxt  = 1'b1;
        pend_nxt       = grp;
        pend_valid_nxt = grp_valid;
      end else if (grp_valid) begin
        act_nxt       = grp;
        act_valid_nxt = 1'b1;
      end else begin
        act_valid_nxt = 1'b0;
      end
    end else begin
      if (out_fire) begin
        idx_nxt = idx_r + 2'd1;
      end
      if (grp_valid) begin
        pend_nxt       = grp;
        pend_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      idx_r        <= 2'd0;
    end else begin
      act_valid_r  <= act_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      idx_r        <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    pend_r <= pend_nxt;
  end

endmodule

// ===== design/base64_encoder_with_key_xor_top.sv =====
// Top level of the keyed base64 encoder: configuration registers and the two stages.
// Depends on b64x_pkg, b64x_pack and b64x_ser.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_data_byte, in_last_byte
//   out_     output     out_valid/out_stall  out_char, out_end_of_message
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// A byte is taken every cycle while the pending group slot is free; each group of
// four characters leaves at one character a cycle while out_stall is low, so
// sustained throughput is set by the output port.
// Reset (synchronous, active low) clears the key registers and the group state.
// A stall on the output holds the active character; the input stalls only when a
// finished group waits behind the one being sent.
module base64_encoder_with_key_xor_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_end_of_message,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic [63:0]      key_low_r;
  logic [63:0]      key_high_r;
  logic [4:0]       key_len_r;
  logic             accept;
  logic             grp_valid;
  logic             full;
  b64x_pkg::group_t grp;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= 64'd0;
      key_high_r <= 64'd0;
      key_len_r  <= 5'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        b64x_pkg::CFG_KEY_LOW:  key_low_r  <= cfg_wdata;
        b64x_pkg::CFG_KEY_HIGH: key_high_r <= cfg_wdata;
        b64x_pkg::CFG_KEY_LEN:  key_len_r  <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  b64x_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .key       ({key_high_r, key_low_r}),
    .key_len   (key_len_r),
    .grp_valid (grp_valid),
    .grp       (grp)
  );

  b64x_ser u_ser (
    .clk                (clk),
    .rst_n              (rst_n),
    .grp_valid          (grp_valid),
    .grp                (grp),
    .full               (full),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_char           (out_char),
    .out_end_of_message (out_end_of_message)
  );

endmodule
